// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
// Each macro takes a label, the clock, an active-low reset and the expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: expression does not hold");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/rtvm_pkg.sv
// ----------------------------------------------------------------------------
// rtvm_pkg
// Types and constants shared by the radix text parser, its channels and checker.
// ----------------------------------------------------------------------------
package rtvm_pkg;

	localparam int VALUE_BITS_DEF = 31;

	localparam int CHAR_W    = 8;
	localparam int RADIX_W   = 6;
	localparam int VALUE_W   = 32;
	localparam int LARGEST_W = 31;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd55;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD      = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

// File: rtl/rtvm_ifs.sv
// ----------------------------------------------------------------------------
// rtvm channel interfaces
// Valid/ready channels for characters in and line results out.
// ----------------------------------------------------------------------------
interface rtvm_char_if;
	logic                        valid;
	logic                        ready;
	logic [rtvm_pkg::CHAR_W-1:0] text_char;
	logic                        line_end;

	modport source (output valid, output text_char, output line_end, input ready);
	modport sink (input valid, input text_char, input line_end, output ready);
endinterface

interface rtvm_result_if;
	logic                                  valid;
	logic                                  ready;
	rtvm_pkg::status_t                     status;
	logic signed [rtvm_pkg::VALUE_W-1:0]   line_value;
	logic [rtvm_pkg::LARGEST_W-1:0]        largest_value;

	modport source (output valid, output status, output line_value, output largest_value,
		input ready);
	modport sink (input valid, input status, input line_value, input largest_value,
		output ready);
endinterface

// File: rtl/radix_text_to_value_max.sv
// Pipeline: an accepted character is registered in the character stage and parsed
// from there; as a line's last character leaves it, the result slot is loaded.
// Throughput: one character per cycle, set by one multiply-add of the accumulator by
// the radix; a line-end item waits only while an earlier result is still unread.
// Reset: line state cleared, largest value 0, radix 10.
// ----------------------------------------------------------------------------
// radix_text_to_value_max
// Parses text lines in a configurable radix and reports each line's status,
// signed value and the running maximum of valid lines.
// ----------------------------------------------------------------------------
module radix_text_to_value_max #(
	parameter int VALUE_BITS = rtvm_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radix_we,
	input  logic [rtvm_pkg::RADIX_W-1:0] radix_wdata,
	rtvm_char_if.sink                    chars,
	rtvm_result_if.source                results
);

	localparam int EXT_W  = (VALUE_BITS > rtvm_pkg::VALUE_W) ? VALUE_BITS : rtvm_pkg::VALUE_W;
	localparam int PROD_W = VALUE_BITS + rtvm_pkg::RADIX_W + 1;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_TRAIL
	} phase_t;

	logic [rtvm_pkg::RADIX_W-1:0] radix_q;

	logic                        valid_s1;
	logic [rtvm_pkg::CHAR_W-1:0] char_s1;
	logic                        end_s1;

	logic [VALUE_BITS-1:0] acc_q;
	phase_t                phase_q;
	logic                  neg_q;
	logic                  seen_q;
	logic                  bad_q;
	logic                  ovf_q;
	logic [VALUE_BITS-1:0] max_q;

	logic                               out_valid_q;
	rtvm_pkg::status_t                  out_status_q;
	logic [rtvm_pkg::VALUE_W-1:0]       out_value_q;
	logic [rtvm_pkg::LARGEST_W-1:0]     out_largest_q;

	logic                         advance;
	logic [rtvm_pkg::RADIX_W-1:0] radix_eff;
	logic [rtvm_pkg::CHAR_W-1:0]  digit_raw;
	logic                         digit_ok;
	logic [rtvm_pkg::RADIX_W-1:0] digit;
	logic                         is_ws;
	logic [PROD_W-1:0]            prod;
	logic                         prod_ovf;
	logic                         do_acc;

	logic [VALUE_BITS-1:0] acc_n;
	phase_t                phase_n;
	logic                  neg_n;
	logic                  seen_n;
	logic                  bad_n;
	logic                  ovf_n;
	logic [VALUE_BITS-1:0] max_n;

	rtvm_pkg::status_t            res_status;
	logic [EXT_W-1:0]             acc_ext;
	logic [EXT_W-1:0]             value_ext;
	logic [EXT_W-1:0]             max_ext;
	logic [rtvm_pkg::VALUE_W-1:0] res_value;

	// A character stage only stalls to close a line while a full result slot is unread.
	assign advance     = valid_s1 && (!end_s1 || !out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;

	always_comb begin
		if (radix_q < rtvm_pkg::RADIX_MIN) begin
			radix_eff = rtvm_pkg::RADIX_MIN;
		end else if (radix_q > rtvm_pkg::RADIX_MAX) begin
			radix_eff = rtvm_pkg::RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	always_comb begin
		digit_raw = '0;
		digit_ok  = 1'b0;
		if (char_s1 >= rtvm_pkg::CH_ZERO && char_s1 <= rtvm_pkg::CH_NINE) begin
			digit_raw = char_s1 - rtvm_pkg::CH_ZERO;
			digit_ok  = 1'b1;
		end else if (char_s1 >= rtvm_pkg::CH_UPPER_A && char_s1 <= rtvm_pkg::CH_UPPER_Z) begin
			digit_raw = char_s1 - rtvm_pkg::LETTER_OFS;
			digit_ok  = 1'b1;
		end
		if (digit_raw >= rtvm_pkg::CHAR_W'(radix_eff)) begin
			digit_ok = 1'b0;
		end
		digit = digit_raw[rtvm_pkg::RADIX_W-1:0];
	end

	assign is_ws = (char_s1 == rtvm_pkg::CH_SPACE) || (char_s1 == rtvm_pkg::CH_NEWLINE);

	// Any bit above the value range means the new magnitude no longer fits.
	assign prod     = PROD_W'(acc_q) * PROD_W'(radix_eff) + PROD_W'(digit);
	assign prod_ovf = |prod[PROD_W-1:VALUE_BITS];

	always_comb begin
		acc_n   = acc_q;
		phase_n = phase_q;
		neg_n   = neg_q;
		seen_n  = seen_q || !is_ws;
		bad_n   = bad_q;
		ovf_n   = ovf_q;
		do_acc  = 1'b0;
		if (!bad_q) begin
			case (phase_q)
				PH_LEAD: begin
					if (char_s1 == rtvm_pkg::CH_SPACE || char_s1 == rtvm_pkg::CH_ZERO) begin
						phase_n = PH_LEAD;
					end else if (char_s1 == rtvm_pkg::CH_NEWLINE) begin
						phase_n = PH_TRAIL;
					end else if (char_s1 == rtvm_pkg::CH_MINUS) begin
						neg_n   = 1'b1;
						phase_n = PH_SIGN;
					end else if (digit_ok) begin
						phase_n = PH_DIGITS;
						do_acc  = 1'b1;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_SIGN: begin
					if (digit_ok) begin
						phase_n = PH_DIGITS;
						do_acc  = 1'b1;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (is_ws) begin
						phase_n = PH_TRAIL;
					end else if (digit_ok) begin
						do_acc = 1'b1;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (!is_ws) begin
						bad_n = 1'b1;
					end
				end
				default: begin
					phase_n = PH_LEAD;
				end
			endcase
		end
		// Once the magnitude has overflowed, further digits are ignored.
		if (do_acc && !ovf_q) begin
			if (prod_ovf) begin
				ovf_n = 1'b1;
			end else begin
				acc_n = prod[VALUE_BITS-1:0];
			end
		end
	end

	always_comb begin
		acc_ext   = EXT_W'(acc_n);
		value_ext = neg_n ? (~acc_ext + EXT_W'(1)) : acc_ext;
		res_value = '0;
		max_n     = max_q;
		if (!seen_n) begin
			res_status = rtvm_pkg::ST_EMPTY;
		end else if (bad_n || phase_n == PH_SIGN) begin
			res_status = rtvm_pkg::ST_BAD;
		end else if (ovf_n) begin
			res_status = rtvm_pkg::ST_OVERFLOW;
		end else begin
			res_status = rtvm_pkg::ST_VALID;
			res_value  = value_ext[rtvm_pkg::VALUE_W-1:0];
			if (!neg_n && acc_n > max_q) begin
				max_n = acc_n;
			end
		end
		max_ext = EXT_W'(max_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= rtvm_pkg::RADIX_RESET;
			valid_s1      <= 1'b0;
			char_s1       <= '0;
			end_s1        <= 1'b0;
			acc_q         <= '0;
			phase_q       <= PH_LEAD;
			neg_q         <= 1'b0;
			seen_q        <= 1'b0;
			bad_q         <= 1'b0;
			ovf_q         <= 1'b0;
			max_q         <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= rtvm_pkg::ST_EMPTY;
			out_value_q   <= '0;
			out_largest_q <= '0;
		end else begin
			if (radix_we) begin
				radix_q <= radix_wdata;
			end
			if (chars.ready) begin
				valid_s1 <= chars.valid;
				char_s1  <= chars.text_char;
				end_s1   <= chars.line_end;
			end
			if (advance) begin
				if (end_s1) begin
					acc_q   <= '0;
					phase_q <= PH_LEAD;
					neg_q   <= 1'b0;
					seen_q  <= 1'b0;
					bad_q   <= 1'b0;
					ovf_q   <= 1'b0;
					max_q   <= max_n;
				end else begin
					acc_q   <= acc_n;
					phase_q <= phase_n;
					neg_q   <= neg_n;
					seen_q  <= seen_n;
					bad_q   <= bad_n;
					ovf_q   <= ovf_n;
				end
			end
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && end_s1) begin
				out_valid_q   <= 1'b1;
				out_status_q  <= res_status;
				out_value_q   <= res_value;
				out_largest_q <= max_ext[rtvm_pkg::LARGEST_W-1:0];
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.status        = out_status_q;
	assign results.line_value    = out_value_q;
	assign results.largest_value = out_largest_q;

endmodule

// File: rtl/rtvm_checker.sv
// ----------------------------------------------------------------------------
// rtvm_checker
// Port-level checks of the radix text parser, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtvm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input rtvm_pkg::status_t              status,
	input logic [rtvm_pkg::VALUE_W-1:0]   line_value,
	input logic [rtvm_pkg::LARGEST_W-1:0] largest_value
);

	logic out_stall;
	logic out_error_line;

	assign out_stall      = out_valid && !out_ready;
	assign out_error_line = out_valid && (status != rtvm_pkg::ST_VALID);

	// A result that is not taken stays offered.
	`ASSERT_NEXT(a_out_valid_holds, clk, arst_n, out_stall, out_valid)

	// A stalled result keeps its payload.
	`ASSERT_NEXT(a_out_payload_holds, clk, arst_n, out_stall, $stable({status, line_value, largest_value}))

	// The parser only refuses a character while a result waits to be taken.
	`ASSERT_IMPLY(a_stall_needs_result, clk, arst_n, !in_ready, out_stall)

	// Lines that are not valid report a zero value.
	`ASSERT_IMPLY(a_zero_unless_valid, clk, arst_n, out_error_line, line_value == '0)

endmodule

bind radix_text_to_value_max rtvm_checker u_rtvm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (chars.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.status        (results.status),
	.line_value    (results.line_value),
	.largest_value (results.largest_value)
);

// File: dv/rtvm_line_checker.sv
// ----------------------------------------------------------------------------
// rtvm_line_checker
// Watches the character and result channels of the radix text parser, predicts
// every line result and compares it field by field with what the block reports.
// ----------------------------------------------------------------------------
module rtvm_line_checker #(
	parameter int VALUE_BITS = rtvm_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radix_we,
	input  logic [rtvm_pkg::RADIX_W-1:0] radix_wdata,
	rtvm_char_if                         chars,
	rtvm_result_if                       results,
	output int                           fail_count,
	output int                           lines_pending,
	output int                           lines_checked,
	output int                           lines_valid
);
	import rtvm_pkg::*;

	typedef enum logic [1:0] {
		SCAN_LEAD   = 2'd0,
		SCAN_SIGN   = 2'd1,
		SCAN_DIGITS = 2'd2,
		SCAN_TRAIL  = 2'd3
	} scan_t;

	typedef struct {
		status_t                     status;
		logic signed [VALUE_W-1:0]   line_value;
		logic [LARGEST_W-1:0]        largest_value;
	} line_result_t;

	localparam logic [7:0]  NOT_A_DIGIT = 8'hFF;
	localparam logic [63:0] MAG_LIMIT   = (64'd1 << VALUE_BITS) - 64'd1;

	logic [RADIX_W-1:0] radix_q;
	logic [63:0]        magnitude;
	logic [63:0]        largest;
	scan_t              scan;
	logic               negative;
	logic               has_content;
	logic               bad_seen;
	logic               overflow_seen;
	line_result_t       expected_lines[$];
	line_result_t       oldest;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH in line result %0d: %s", $time, lines_checked, msg);
		fail_count++;
	endtask

	task automatic clear_line();
		magnitude     = '0;
		scan          = SCAN_LEAD;
		negative      = 1'b0;
		has_content   = 1'b0;
		bad_seen      = 1'b0;
		overflow_seen = 1'b0;
	endtask

	function automatic logic [7:0] digit_value(input logic [7:0] c, input int unsigned base);
		logic [7:0] d;
		d = NOT_A_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
		else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) d = c - LETTER_OFS;
		if (d != NOT_A_DIGIT && d >= base) d = NOT_A_DIGIT;
		return d;
	endfunction

	// Once the magnitude would pass the limit, it freezes and the line is marked.
	task automatic add_digit(input logic [7:0] d, input int unsigned base);
		if (!overflow_seen) begin
			if (magnitude > (MAG_LIMIT - 64'(d)) / 64'(base)) overflow_seen = 1'b1;
			else magnitude = magnitude * 64'(base) + 64'(d);
		end
	endtask

	task automatic predict_char(input logic [7:0] c, input logic last);
		int unsigned  base;
		logic         blank;
		logic [7:0]   d;
		line_result_t res;
		base  = (radix_q < RADIX_MIN) ? 2 : (radix_q > RADIX_MAX) ? 36 : int'(radix_q);
		blank = (c == CH_SPACE) || (c == CH_NEWLINE);
		d     = digit_value(c, base);
		if (!blank) has_content = 1'b1;
		if (!bad_seen) begin
			case (scan)
				SCAN_LEAD: begin
					if (c == CH_NEWLINE) scan = SCAN_TRAIL;
					else if (c == CH_MINUS) begin
						negative = 1'b1;
						scan     = SCAN_SIGN;
					end else if (c == CH_SPACE || c == CH_ZERO) scan = SCAN_LEAD;
					else if (d != NOT_A_DIGIT) begin
						scan = SCAN_DIGITS;
						add_digit(d, base);
					end else bad_seen = 1'b1;
				end
				SCAN_SIGN: begin
					if (d != NOT_A_DIGIT) begin
						scan = SCAN_DIGITS;
						add_digit(d, base);
					end else bad_seen = 1'b1;
				end
				SCAN_DIGITS: begin
					if (blank) scan = SCAN_TRAIL;
					else if (d != NOT_A_DIGIT) add_digit(d, base);
					else bad_seen = 1'b1;
				end
				default: begin
					if (!blank) bad_seen = 1'b1;
				end
			endcase
		end
		if (last) begin
			res.line_value = '0;
			// An all-blank line reports empty ahead of any other status.
			if (!has_content) res.status = ST_EMPTY;
			else if (bad_seen || scan == SCAN_SIGN) res.status = ST_BAD;
			else if (overflow_seen) res.status = ST_OVERFLOW;
			else begin
				res.status     = ST_VALID;
				res.line_value = negative ? (32'd0 - magnitude[31:0]) : magnitude[31:0];
				if (!negative && magnitude > largest) largest = magnitude;
			end
			res.largest_value = largest[LARGEST_W-1:0];
			expected_lines.push_back(res);
			lines_pending++;
			clear_line();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q = RADIX_RESET;
			largest = '0;
			clear_line();
			expected_lines.delete();
			fail_count    = 0;
			lines_pending = 0;
			lines_checked = 0;
			lines_valid   = 0;
		end else begin
			if (chars.valid && chars.ready) predict_char(chars.text_char, chars.line_end);
			if (results.valid && results.ready) begin
				lines_checked++;
				if (lines_pending == 0) report_mismatch("result arrived with no line pending");
				else begin
					oldest = expected_lines.pop_front();
					lines_pending--;
					if (results.status !== oldest.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							results.status, oldest.status));
					if (results.line_value !== oldest.line_value)
						report_mismatch($sformatf("line_value %0d, expected %0d",
							results.line_value, oldest.line_value));
					if (results.largest_value !== oldest.largest_value)
						report_mismatch($sformatf("largest_value %0d, expected %0d",
							results.largest_value, oldest.largest_value));
					if (oldest.status == ST_VALID) lines_valid++;
				end
			end
			if (radix_we) radix_q = radix_wdata;
		end
	end

endmodule

// File: dv/tb_radix_text_to_value_max.sv
// ----------------------------------------------------------------------------
// tb_radix_text_to_value_max
// Feeds text lines through the radix parser under several radix settings, with
// random gaps on both channels; a checker beside the block judges every line.
// ----------------------------------------------------------------------------
module tb_radix_text_to_value_max;
	import rtvm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_CHARS = 35;
	localparam int PLAN_LEN    = 8;
	localparam logic [RADIX_W-1:0] RADIX_PLAN [PLAN_LEN] = '{
		6'd36, 6'd2, 6'd16, 6'd0, 6'd1, 6'd37, 6'd63, 6'd7
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               radix_we;
	logic [RADIX_W-1:0] radix_wdata;
	logic [RADIX_W-1:0] current_radix;
	logic               calm = 1'b0;
	logic [7:0]         line_buf[$];
	int                 chars_sent = 0;
	int                 settings_used = 1;
	int                 cycle_count = 0;
	int                 fail_count;
	int                 lines_pending;
	int                 lines_checked;
	int                 lines_valid;

	rtvm_char_if   chars_if ();
	rtvm_result_if results_if ();

	radix_text_to_value_max uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.chars       (chars_if),
		.results     (results_if)
	);

	rtvm_line_checker u_line_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.radix_we      (radix_we),
		.radix_wdata   (radix_wdata),
		.chars         (chars_if),
		.results       (results_if),
		.fail_count    (fail_count),
		.lines_pending (lines_pending),
		.lines_checked (lines_checked),
		.lines_valid   (lines_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		results_if.ready <= calm || ($urandom_range(0, 99) >= 30);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d lines pending", cycle_count,
				lines_pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] digit_char(input int unsigned d);
		return (d < 10) ? CH_ZERO + 8'(d) : LETTER_OFS + 8'(d);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last);
		if (!calm) begin
			while ($urandom_range(0, 99) < 30) begin
				chars_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		chars_if.valid     <= 1'b1;
		chars_if.text_char <= c;
		chars_if.line_end  <= last;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
	endtask

	// Most lines are well formed with random content; the rest are blank lines,
	// byte noise, or well-formed lines with one character overwritten.
	task automatic build_line();
		int unsigned kind;
		int unsigned base;
		int unsigned n;
		line_buf.delete();
		base = (current_radix < RADIX_MIN) ? 2 :
			(current_radix > RADIX_MAX) ? 36 : int'(current_radix);
		kind = $urandom_range(0, 99);
		if (kind >= 95) begin
			n = $urandom_range(1, 3);
			repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
		end else if (kind >= 85) begin
			n = $urandom_range(1, 5);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 2);
			repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_ZERO);
			if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_MINUS);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 34) : $urandom_range(1, 5);
			repeat (n) line_buf.push_back(digit_char($urandom_range(0, base - 1)));
			n = $urandom_range(0, 2);
			repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
			if (kind >= 70)
				line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end
	endtask

	task automatic random_lines(input int count);
		int start;
		start = chars_sent;
		while (chars_sent - start < count) begin
			build_line();
			send_line();
		end
	endtask

	// Drops valid, waits for every pending line result, then lets the pipeline settle.
	task automatic wait_for_results();
		chars_if.valid <= 1'b0;
		@(negedge clk);
		while (lines_pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] value);
		radix_we      <= 1'b1;
		radix_wdata   <= value;
		current_radix = value;
		settings_used++;
		@(posedge clk);
		radix_we <= 1'b0;
	endtask

	initial begin
		arst_n              <= 1'b0;
		radix_we            <= 1'b0;
		radix_wdata         <= RADIX_RESET;
		chars_if.valid      <= 1'b0;
		chars_if.text_char  <= '0;
		chars_if.line_end   <= 1'b0;
		current_radix       = RADIX_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Special cases at the reset radix.
		send_text(" \n");
		send_text("00 ");
		send_text("-0\n");
		send_text("-");
		send_text("\n5");
		send_text("1 2");
		send_text("- 3");
		send_text("42 ");
		send_text("-99");
		send_text("A");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		random_lines(PHASE_CHARS);

		for (int p = 0; p <= PLAN_LEN; p++) begin
			wait_for_results();
			if (p < PLAN_LEN) write_radix(RADIX_PLAN[p]);
			else write_radix(RADIX_W'($urandom_range(2, 36)));
			calm = (p == 2);
			if (current_radix == RADIX_MAX) begin
				// Largest magnitude, its negation, one past it, and bad over overflow.
				send_text("ZIK0ZJ");
				send_text("-ZIK0ZJ");
				send_text("ZIK0ZK");
				send_text("ZZZZZZZ?");
			end
			random_lines(PHASE_CHARS);
		end
		calm = 1'b0;
		wait_for_results();

		$display("Sent %0d characters under %0d radix settings, out-of-range codes included.",
			chars_sent, settings_used);
		$display("Checked %0d line results, %0d of them valid, with %0d mismatches.",
			lines_checked, lines_valid, fail_count);
		if (fail_count == 0 && lines_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/rtvm_pkg.sv
rtl/rtvm_ifs.sv
rtl/radix_text_to_value_max.sv
rtl/rtvm_checker.sv
dv/rtvm_line_checker.sv
dv/tb_radix_text_to_value_max.sv
